### rtl/rgbhsv_pkg.sv
// Package for the RGB to HSV converter: widths, constants and the item record
// that travels down the divider cell chain. Used by every module in rtl/.
`default_nettype none

package rgbhsv_pkg;

	localparam int unsigned ChanW   = 8;
	localparam int unsigned HueW    = 9;
	localparam int unsigned RemW    = 17;
	// One cell per quotient bit; the hue quotient is the wider of the two.
	localparam int unsigned NumCells = HueW;
	localparam logic [HueW-1:0] HueMax = 9'd359;

	typedef struct packed {
		logic              gray;
		logic [ChanW-1:0]  value;
		logic [RemW-1:0]   hue_rem;
		logic [ChanW-1:0]  hue_div;
		logic [HueW-1:0]   hue_quo;
		logic [RemW-1:0]   sat_rem;
		logic [ChanW-1:0]  sat_div;
		logic [HueW-1:0]   sat_quo;
	} item_t;

endpackage

`default_nettype wire

### rtl/rgbhsv_prep.sv
// Front stage of the converter: max, min, delta and the two division numerators.
// Depends on rgbhsv_pkg.
`default_nettype none

module rgbhsv_prep (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_vld,
	input  wire logic [rgbhsv_pkg::ChanW-1:0] red,
	input  wire logic [rgbhsv_pkg::ChanW-1:0] green,
	input  wire logic [rgbhsv_pkg::ChanW-1:0] blue,
	output logic                              vld_s1,
	output rgbhsv_pkg::item_t                 item_s1
);

	logic [rgbhsv_pkg::ChanW-1:0] mx, mn, delta;
	logic [rgbhsv_pkg::RemW-1:0]  dlt_w, hue_num;
	rgbhsv_pkg::item_t            item_d;

	always_comb begin
		mx = (red > green) ? red : green;
		if (blue > mx) begin
			mx = blue;
		end
		mn = (red < green) ? red : green;
		if (blue < mn) begin
			mn = blue;
		end
		delta = mx - mn;
		dlt_w = rgbhsv_pkg::RemW'(delta);

		// Hue numerator over delta, always nonnegative, tested red, green, blue.
		if (red == mx) begin
			if (green >= blue) begin
				hue_num = 17'd60 * rgbhsv_pkg::RemW'(green - blue);
			end else begin
				hue_num = 17'd360 * dlt_w - 17'd60 * rgbhsv_pkg::RemW'(blue - green);
			end
		end else if (green == mx) begin
			if (blue >= red) begin
				hue_num = 17'd120 * dlt_w + 17'd60 * rgbhsv_pkg::RemW'(blue - red);
			end else begin
				hue_num = 17'd120 * dlt_w - 17'd60 * rgbhsv_pkg::RemW'(red - blue);
			end
		end else begin
			if (red >= green) begin
				hue_num = 17'd240 * dlt_w + 17'd60 * rgbhsv_pkg::RemW'(red - green);
			end else begin
				hue_num = 17'd240 * dlt_w - 17'd60 * rgbhsv_pkg::RemW'(green - red);
			end
		end

		item_d.gray    = (delta == '0);
		item_d.value   = mx;
		item_d.hue_rem = hue_num;
		item_d.hue_div = delta;
		item_d.hue_quo = '0;
		// 255 * delta as a shift and subtract.
		item_d.sat_rem = {1'b0, delta, 8'b0} - dlt_w;
		item_d.sat_div = mx;
		item_d.sat_quo = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item_d;
	end

endmodule

`default_nettype wire

### rtl/rgbhsv_div_cell.sv
// One cell of the divider chain: settles one quotient bit of both the hue and
// the saturation division and hands the item on. Depends on rgbhsv_pkg.
`default_nettype none

module rgbhsv_div_cell #(
	parameter int unsigned BIT = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              vld_in,
	input  wire rgbhsv_pkg::item_t item_in,
	output logic                   vld_q,
	output rgbhsv_pkg::item_t      item_q
);

	logic [rgbhsv_pkg::RemW-1:0] hue_trial, sat_trial;
	rgbhsv_pkg::item_t           item_d;

	always_comb begin
		item_d    = item_in;
		hue_trial = rgbhsv_pkg::RemW'(item_in.hue_div) << BIT;
		sat_trial = rgbhsv_pkg::RemW'(item_in.sat_div) << BIT;
		if (item_in.hue_rem >= hue_trial) begin
			item_d.hue_rem      = item_in.hue_rem - hue_trial;
			item_d.hue_quo[BIT] = 1'b1;
		end
		if (item_in.sat_rem >= sat_trial) begin
			item_d.sat_rem      = item_in.sat_rem - sat_trial;
			item_d.sat_quo[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
	end

endmodule

`default_nettype wire

### rtl/rgb_to_hsv_convert.sv
// RGB to HSV converter, one pixel item per clock, never busy.
// From start to the done strobe an item passes one front stage,
// then nine divider cells, one quotient bit per cell.
// Throughput: one item every cycle; the nine-cell divider chain sets the depth.
// Reset clears the valid bits of all stages; no result follows until fed.
// The receiver cannot stall: each result shows for one cycle with done high.
`default_nettype none

module rgb_to_hsv_convert (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [rgbhsv_pkg::ChanW-1:0] red,
	input  wire logic [rgbhsv_pkg::ChanW-1:0] green,
	input  wire logic [rgbhsv_pkg::ChanW-1:0] blue,
	output logic                              done,
	output logic [rgbhsv_pkg::HueW-1:0]       hue,
	output logic [rgbhsv_pkg::ChanW-1:0]      saturation,
	output logic [rgbhsv_pkg::ChanW-1:0]      value
);

	logic              vld_chain  [rgbhsv_pkg::NumCells+1];
	rgbhsv_pkg::item_t item_chain [rgbhsv_pkg::NumCells+1];
	rgbhsv_pkg::item_t last;

	assign busy = 1'b0;

	rgbhsv_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.vld_s1  (vld_chain[0]),
		.item_s1 (item_chain[0])
	);

	// Cell k settles quotient bit (NumCells-1-k), most significant first.
	for (genvar k = 0; k < rgbhsv_pkg::NumCells; k++) begin : g_cell
		rgbhsv_div_cell #(
			.BIT(rgbhsv_pkg::NumCells - 1 - k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (vld_chain[k]),
			.item_in (item_chain[k]),
			.vld_q   (vld_chain[k+1]),
			.item_q  (item_chain[k+1])
		);
	end

	assign last  = item_chain[rgbhsv_pkg::NumCells];
	assign done  = vld_chain[rgbhsv_pkg::NumCells];
	assign value = last.value;

	// A gray item divides its hue by zero in the chain; its quotients are discarded.
	always_comb begin
		if (last.gray) begin
			hue        = '0;
			saturation = '0;
		end else begin
			hue        = (last.hue_quo > rgbhsv_pkg::HueMax) ? rgbhsv_pkg::HueMax
				: last.hue_quo;
			saturation = last.sat_quo[rgbhsv_pkg::ChanW-1:0];
		end
	end

endmodule

`default_nettype wire
